@@ rtl/wgtl_pkg.sv @@
// Package for the wind grid trilinear lookup: sizes, item structs,
// configuration register codes and the command passed from front to back.
// No dependencies.
`default_nettype none

package wgtl_pkg;

    // grid dimensions
    localparam int GRID_POINTS = 16;
    localparam int TIME_STEPS  = 256;
    localparam int GP_W        = $clog2(GRID_POINTS);
    localparam int TS_W        = $clog2(TIME_STEPS);

    // eight banks, one for each parity of (row, column, step)
    localparam int BANK_AW    = 2 * (GP_W - 1) + (TS_W - 1);
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    // command queue and result buffer
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_FIELD_SIZE        = 3'd0,
        REG_SIM_DURATION      = 3'd1,
        REG_HUB_SPEED         = 3'd2,
        REG_INV_HUB_SPEED     = 3'd3,
        REG_INV_SPATIAL_STEP  = 3'd4,
        REG_INV_TEMPORAL_STEP = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         grid_row;
        logic [3:0]         grid_col;
        logic [7:0]         grid_step;
        logic signed [31:0] sample_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] query_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] speed;
        logic               outside;
    } out_item_t;

    typedef struct packed {
        logic [30:0]        field_size;
        logic [30:0]        sim_duration;
        logic signed [31:0] hub_speed;
        logic signed [31:0] inv_hub_speed;
        logic [30:0]        inv_spatial_step;
        logic [30:0]        inv_temporal_step;
    } cfg_t;

    // load: row/col/step address and data; query: base indices and fractions
    typedef struct packed {
        logic            kind;
        logic            outside;
        logic [GP_W-1:0] row;
        logic [GP_W-1:0] col;
        logic [TS_W-1:0] step;
        logic [31:0]     data;
        logic [15:0]     fz;
        logic [15:0]     fy;
        logic [15:0]     ft;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/wgtl_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module wgtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/wgtl_front.sv @@
// Front end: accepts items, applies the transport delay, tests bounds and
// computes grid indices and fractions; pushes commands. Uses wgtl_pkg.
`default_nettype none

module wgtl_front
    import wgtl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_data,
    input  wire logic [QUEUE_AW:0]   q_count,
    output logic                     push,
    output cmd_t                     push_data
);

    // stage 0: captured item
    logic     v0_reg;
    in_item_t it0_reg;

    // stage 1: positions and delay partial products
    logic               v1_reg, kind1_reg, load_ok1_reg;
    logic [3:0]         row1_reg, col1_reg;
    logic [7:0]         step1_reg;
    logic [31:0]        data1_reg;
    logic signed [32:0] z1_reg, y1_reg;
    logic signed [31:0] time1_reg;
    logic signed [48:0] ph1_reg;
    logic signed [49:0] pl1_reg;

    // stage 2: bounded coordinates
    logic        v2_reg, kind2_reg, load_ok2_reg, out2_reg;
    logic [3:0]  row2_reg, col2_reg;
    logic [7:0]  step2_reg;
    logic [31:0] data2_reg;
    logic [30:0] z2_reg, y2_reg, t2_reg;

    logic               accept;
    logic [QUEUE_AW+1:0] pending;
    logic signed [32:0] half_s, z_next, y_next, d_next;
    logic signed [48:0] ph_next;
    logic signed [49:0] pl_next;
    logic               load_ok_next;
    logic signed [65:0] prod;
    logic signed [50:0] t1;
    logic               out1;
    logic [61:0]        uz, uy, ut;
    logic [29:0]        zi, yi;
    logic [30:0]        ti;
    logic               edge_out;

    // credit check: everything in flight must fit in the queue
    assign pending = (QUEUE_AW+2)'(q_count) + (QUEUE_AW+2)'(v0_reg)
                   + (QUEUE_AW+2)'(v1_reg) + (QUEUE_AW+2)'(v2_reg);
    assign s_ready = pending < (QUEUE_AW+2)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    // stage 0 math: centered positions and transport delay partial products
    always_comb begin
        half_s  = $signed({3'b000, cfg.field_size[30:1]});
        z_next  = 33'(it0_reg.pos_z) + half_s;
        y_next  = 33'(it0_reg.pos_y) + half_s;
        d_next  = half_s - 33'(it0_reg.pos_x);
        ph_next = d_next * $signed(cfg.inv_hub_speed[31:16]);
        pl_next = d_next * $signed({1'b0, cfg.inv_hub_speed[15:0]});
        load_ok_next = ({28'd0, it0_reg.grid_row} < 32'(GRID_POINTS))
                    && ({28'd0, it0_reg.grid_col} < 32'(GRID_POINTS))
                    && ({24'd0, it0_reg.grid_step} < 32'(TIME_STEPS));
    end

    // stage 1 math: delayed time and bounds test
    always_comb begin
        prod = (66'(ph1_reg) <<< 16) + 66'(pl1_reg);
        t1   = 51'(time1_reg) + 51'($signed(prod[65:16]));
        out1 = z1_reg[32] || y1_reg[32] || t1[50]
            || (z1_reg >= $signed({2'b00, cfg.field_size}))
            || (y1_reg >= $signed({2'b00, cfg.field_size}))
            || (t1 >= $signed({20'd0, cfg.sim_duration}));
    end

    // stage 2 math: index and fraction products, edge test
    always_comb begin
        uz = z2_reg * cfg.inv_spatial_step;
        uy = y2_reg * cfg.inv_spatial_step;
        ut = t2_reg * cfg.inv_temporal_step;
        zi = uz[61:32];
        yi = uy[61:32];
        ti = 31'(ut[61:32]);
        edge_out = (zi > 30'(GRID_POINTS - 2)) || (yi > 30'(GRID_POINTS - 2))
                || (ti > 31'(TIME_STEPS - 2));
    end

    // command out of stage 2; out-of-range loads are dropped
    always_comb begin
        push              = v2_reg && (kind2_reg == KIND_QUERY || load_ok2_reg);
        push_data.kind    = kind2_reg;
        push_data.outside = out2_reg || edge_out;
        push_data.data    = data2_reg;
        push_data.fz      = uz[31:16];
        push_data.fy      = uy[31:16];
        push_data.ft      = ut[31:16];
        if (kind2_reg == KIND_QUERY) begin
            push_data.row  = GP_W'(zi);
            push_data.col  = GP_W'(yi);
            push_data.step = TS_W'(ti);
        end else begin
            push_data.row  = GP_W'(row2_reg);
            push_data.col  = GP_W'(col2_reg);
            push_data.step = TS_W'(step2_reg);
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        it0_reg      <= s_data;
        kind1_reg    <= it0_reg.kind;
        load_ok1_reg <= load_ok_next;
        row1_reg     <= it0_reg.grid_row;
        col1_reg     <= it0_reg.grid_col;
        step1_reg    <= it0_reg.grid_step;
        data1_reg    <= it0_reg.sample_value;
        z1_reg       <= z_next;
        y1_reg       <= y_next;
        time1_reg    <= it0_reg.query_time;
        ph1_reg      <= ph_next;
        pl1_reg      <= pl_next;
        kind2_reg    <= kind1_reg;
        load_ok2_reg <= load_ok1_reg;
        out2_reg     <= out1;
        row2_reg     <= row1_reg;
        col2_reg     <= col1_reg;
        step2_reg    <= step1_reg;
        data2_reg    <= data1_reg;
        z2_reg       <= z1_reg[30:0];
        y2_reg       <= y1_reg[30:0];
        t2_reg       <= t1[30:0];
    end

endmodule

`default_nettype wire

@@ rtl/wgtl_queue.sv @@
// Command queue between front and back ends.
// Uses wgtl_pkg.
`default_nettype none

module wgtl_queue
    import wgtl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire cmd_t              push_data,
    input  wire logic              pop,
    output cmd_t                   head,
    output logic [QUEUE_AW:0]      count
);

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign head  = mem_reg[rd_reg];
    assign count = count_reg;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/wgtl_back.sv @@
// Back end: banked grid memory, three lerp stages and the result buffer.
// Uses wgtl_pkg and wgtl_ram.
`default_nettype none

module wgtl_back
    import wgtl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [31:0] hub_speed,
    input  wire cmd_t               head,
    input  wire logic [QUEUE_AW:0]  q_count,
    output logic                    pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data
);

    function automatic logic signed [49:0] lerp_mul(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic [15:0]        f
    );
        logic signed [32:0] diff;
        diff = 33'(b) - 33'(a);
        return diff * $signed({1'b0, f});
    endfunction

    function automatic logic signed [31:0] lerp_add(
        input logic signed [31:0] a,
        input logic signed [49:0] p
    );
        logic signed [33:0] s;
        s = 34'(a) + 34'(p >>> 16);
        return s[31:0];
    endfunction

    logic [31:0] bank_rd [8];

    // stage registers
    logic        b1_v_reg, b1_out_reg;
    logic [2:0]  b1_par_reg;
    logic [15:0] b1_fz_reg, b1_fy_reg, b1_ft_reg;

    logic               b2_v_reg, b2_out_reg;
    logic [15:0]        b2_fy_reg, b2_ft_reg;
    logic signed [31:0] b2_a_reg [4];
    logic signed [49:0] b2_p_reg [4];

    logic               b3_v_reg, b3_out_reg;
    logic [15:0]        b3_ft_reg;
    logic signed [31:0] b3_a_reg [2];
    logic signed [49:0] b3_p_reg [2];

    logic               b4_v_reg, b4_out_reg;
    logic signed [31:0] b4_a_reg;
    logic signed [49:0] b4_p_reg;

    // result buffer
    out_item_t         out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] owr_reg, ord_reg;
    logic [OUT_AW:0]   ocnt_reg;

    logic [OUT_AW+2:0]  pending;
    logic               is_load, out_pop;
    logic signed [31:0] za [4], zb [4];
    logic signed [49:0] zp [4];
    logic signed [31:0] yv [4];
    logic signed [49:0] yp [2];
    logic signed [31:0] tv [2];
    logic signed [49:0] tp;
    logic signed [31:0] res;
    out_item_t          res_item;

    // pop only when the result buffer has room for everything in flight
    assign pending = (OUT_AW+3)'(ocnt_reg) + (OUT_AW+3)'(b1_v_reg)
                   + (OUT_AW+3)'(b2_v_reg) + (OUT_AW+3)'(b3_v_reg)
                   + (OUT_AW+3)'(b4_v_reg);
    assign pop     = (q_count != '0) && (pending < (OUT_AW+3)'(OUT_DEPTH));
    assign is_load = head.kind == KIND_LOAD;

    // grid banks selected by parity of row, column and step
    for (genvar k = 0; k < 8; k++) begin : g_bank
        localparam logic [2:0] KB = 3'(k);
        logic            we;
        logic [GP_W-1:0] r, c;
        logic [TS_W-1:0] s;
        logic [BANK_AW-1:0] waddr, raddr;

        always_comb begin
            we = pop && is_load && head.row[0] == KB[2] && head.col[0] == KB[1]
              && head.step[0] == KB[0];
            r = head.row + GP_W'(KB[2] ^ head.row[0]);
            c = head.col + GP_W'(KB[1] ^ head.col[0]);
            s = head.step + TS_W'(KB[0] ^ head.step[0]);
            waddr = {head.row[GP_W-1:1], head.col[GP_W-1:1], head.step[TS_W-1:1]};
            raddr = {r[GP_W-1:1], c[GP_W-1:1], s[TS_W-1:1]};
        end

        wgtl_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (head.data),
            .raddr (raddr),
            .rdata (bank_rd[k])
        );
    end

    // height lerps; pair j uses lateral offset j[0] and time offset j[1]
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            za[j] = $signed(bank_rd[{b1_par_reg[2], b1_par_reg[1] ^ j[0],
                                     b1_par_reg[0] ^ j[1]}]);
            zb[j] = $signed(bank_rd[{~b1_par_reg[2], b1_par_reg[1] ^ j[0],
                                     b1_par_reg[0] ^ j[1]}]);
            zp[j] = lerp_mul(za[j], zb[j], b1_fz_reg);
        end
    end

    // lateral lerps
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            yv[j] = lerp_add(b2_a_reg[j], b2_p_reg[j]);
        end
        yp[0] = lerp_mul(yv[0], yv[1], b2_fy_reg);
        yp[1] = lerp_mul(yv[2], yv[3], b2_fy_reg);
    end

    // time lerp and result
    always_comb begin
        tv[0] = lerp_add(b3_a_reg[0], b3_p_reg[0]);
        tv[1] = lerp_add(b3_a_reg[1], b3_p_reg[1]);
        tp    = lerp_mul(tv[0], tv[1], b3_ft_reg);
        res   = lerp_add(b4_a_reg, b4_p_reg);
        res_item.outside = b4_out_reg;
        res_item.speed   = b4_out_reg ? hub_speed : res;
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
        end else begin
            b1_v_reg <= pop && !is_load;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        b1_out_reg <= head.outside;
        b1_par_reg <= {head.row[0], head.col[0], head.step[0]};
        b1_fz_reg  <= head.fz;
        b1_fy_reg  <= head.fy;
        b1_ft_reg  <= head.ft;
        b2_out_reg <= b1_out_reg;
        b2_fy_reg  <= b1_fy_reg;
        b2_ft_reg  <= b1_ft_reg;
        for (int j = 0; j < 4; j++) begin
            b2_a_reg[j] <= za[j];
            b2_p_reg[j] <= zp[j];
        end
        b3_out_reg  <= b2_out_reg;
        b3_ft_reg   <= b2_ft_reg;
        b3_a_reg[0] <= yv[0];
        b3_a_reg[1] <= yv[2];
        b3_p_reg[0] <= yp[0];
        b3_p_reg[1] <= yp[1];
        b4_out_reg  <= b3_out_reg;
        b4_a_reg    <= tv[0];
        b4_p_reg    <= tp;
    end

    // result buffer
    assign m_valid = ocnt_reg != '0;
    assign m_data  = out_mem_reg[ord_reg];
    assign out_pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end else begin
            if (b4_v_reg) begin
                owr_reg <= owr_reg + 1'b1;
            end
            if (out_pop) begin
                ord_reg <= ord_reg + 1'b1;
            end
            ocnt_reg <= ocnt_reg + (OUT_AW+1)'(b4_v_reg) - (OUT_AW+1)'(out_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (b4_v_reg) begin
            out_mem_reg[owr_reg] <= res_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/wind_grid_trilinear_lookup.sv @@
// Wind grid trilinear lookup, top level: configuration registers, front end,
// command queue and back end. Uses wgtl_pkg, wgtl_front, wgtl_queue, wgtl_back.
// Path: front end pipeline, command queue, back end pipeline, result buffer.
// Throughput: one item per cycle unless stalled, limited by one grid access per cycle.
// Reset clears configuration, queue and pipeline valid bits; the grid holds
// no defined value until loaded, and there is no clearing pass.
`default_nettype none

module wind_grid_trilinear_lookup
    import wgtl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              push, pop;
    cmd_t              push_data, head;
    logic [QUEUE_AW:0] q_count;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FIELD_SIZE:        cfg_reg.field_size        <= cfg_data[30:0];
                REG_SIM_DURATION:      cfg_reg.sim_duration      <= cfg_data[30:0];
                REG_HUB_SPEED:         cfg_reg.hub_speed         <= cfg_data;
                REG_INV_HUB_SPEED:     cfg_reg.inv_hub_speed     <= cfg_data;
                REG_INV_SPATIAL_STEP:  cfg_reg.inv_spatial_step  <= cfg_data[30:0];
                REG_INV_TEMPORAL_STEP: cfg_reg.inv_temporal_step <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    wgtl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    wgtl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    wgtl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hub_speed (cfg_reg.hub_speed),
        .head      (head),
        .q_count   (q_count),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for wind_grid_trilinear_lookup: grid loads and speed queries
// checked against a predictor of the trilinear lookup, over several register settings.
// Depends on wgtl_pkg and the RTL of the block.
`default_nettype none

module tb_top;
    import wgtl_pkg::*;

    localparam int  STORE_WORDS = GRID_POINTS * GRID_POINTS * TIME_STEPS;
    localparam int  PHASE_ITEMS = 215;
    localparam int  NUM_PHASES  = 9;
    localparam int  SETTLE      = 30;
    localparam longint LIMIT    = 1500000;

    typedef struct {
        bit     off_grid;
        longint zi, yi, ti;
        longint fz, fy, ft;
    } cell_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // register mirror, grid mirror and what the stimulus has written so far
    cfg_t               regs = '0;
    logic signed [31:0] wind_grid [STORE_WORDS];
    bit                 word_loaded [STORE_WORDS];

    in_item_t  pending_items[$];
    out_item_t expected_speeds[$];

    int     fail_count = 0;
    int     queries_seen = 0;
    int     outside_seen = 0;
    int     loads_sent = 0;
    int     items_sent = 0;
    bit     no_idle = 1'b0;
    int     send_gap = 0;
    int     stall_gap = 0;
    longint cycle_count = 0;

    wind_grid_trilinear_lookup uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int grid_addr(longint r, longint c, longint s);
        return int'((r * GRID_POINTS + c) * TIME_STEPS + s);
    endfunction

    // grid cell and fractions of a query after the transport delay
    function automatic cell_t locate(in_item_t it);
        cell_t  c;
        longint half, z, y, t, uz, uy, ut;
        half = longint'(regs.field_size) >> 1;
        z = longint'(it.pos_z) + half;
        y = longint'(it.pos_y) + half;
        t = longint'(it.query_time)
            + (((half - longint'(it.pos_x)) * longint'(regs.inv_hub_speed)) >>> 16);
        c = '{default: 0};
        c.off_grid = z < 0 || y < 0 || t < 0 || z >= longint'(regs.field_size)
            || y >= longint'(regs.field_size) || t >= longint'(regs.sim_duration);
        if (!c.off_grid) begin
            uz = z * longint'(regs.inv_spatial_step);
            uy = y * longint'(regs.inv_spatial_step);
            ut = t * longint'(regs.inv_temporal_step);
            c.zi = uz >>> 32;  c.fz = (uz >>> 16) & 'hFFFF;
            c.yi = uy >>> 32;  c.fy = (uy >>> 16) & 'hFFFF;
            c.ti = ut >>> 32;  c.ft = (ut >>> 16) & 'hFFFF;
            if (c.zi > GRID_POINTS - 2 || c.yi > GRID_POINTS - 2 || c.ti > TIME_STEPS - 2)
                c.off_grid = 1'b1;
        end
        return c;
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic longint grid_word(longint r, longint c, longint s);
        return longint'(wind_grid[grid_addr(r, c, s)]);
    endfunction

    // interpolated speed: height, then lateral, then time
    function automatic out_item_t interpolate_speed(in_item_t it);
        cell_t     c;
        out_item_t o;
        longint    v00, v01, v10, v11, vt0, vt1;
        c = locate(it);
        if (c.off_grid) begin
            o.speed = regs.hub_speed;
            o.outside = 1'b1;
            return o;
        end
        v00 = blend(grid_word(c.zi, c.yi, c.ti), grid_word(c.zi + 1, c.yi, c.ti), c.fz);
        v01 = blend(grid_word(c.zi, c.yi + 1, c.ti),
                    grid_word(c.zi + 1, c.yi + 1, c.ti), c.fz);
        vt0 = blend(v00, v01, c.fy);
        v10 = blend(grid_word(c.zi, c.yi, c.ti + 1),
                    grid_word(c.zi + 1, c.yi, c.ti + 1), c.fz);
        v11 = blend(grid_word(c.zi, c.yi + 1, c.ti + 1),
                    grid_word(c.zi + 1, c.yi + 1, c.ti + 1), c.fz);
        vt1 = blend(v10, v11, c.fy);
        o.speed = 32'(blend(vt0, vt1, c.ft));
        o.outside = 1'b0;
        return o;
    endfunction

    // driver: one payload per transfer, prediction at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                if (s_data.kind == KIND_LOAD)
                    wind_grid[grid_addr(s_data.grid_row, s_data.grid_col, s_data.grid_step)]
                        = s_data.sample_value;
                else
                    expected_speeds.push_back(interpolate_speed(s_data));
            end
            if (send_gap > 0 || pending_items.size() == 0) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap <= pick_gap();
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_speeds.size() == 0) begin
                    $error("result with no query pending: speed %0d outside %0b",
                           m_data.speed, m_data.outside);
                    fail_count++;
                end else begin
                    want = expected_speeds.pop_front();
                    queries_seen++;
                    if (want.outside) outside_seen++;
                    if (m_data.speed !== want.speed) begin
                        $error("speed: expected %0d, actual %0d", want.speed, m_data.speed);
                        fail_count++;
                    end
                    if (m_data.outside !== want.outside) begin
                        $error("outside: expected %0b, actual %0b",
                               want.outside, m_data.outside);
                        fail_count++;
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_FIELD_SIZE:        regs.field_size = value[30:0];
            REG_SIM_DURATION:      regs.sim_duration = value[30:0];
            REG_HUB_SPEED:         regs.hub_speed = value;
            REG_INV_HUB_SPEED:     regs.inv_hub_speed = value;
            REG_INV_SPATIAL_STEP:  regs.inv_spatial_step = value[30:0];
            REG_INV_TEMPORAL_STEP: regs.inv_temporal_step = value[30:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_speeds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic in_item_t noise_item();
        in_item_t     it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    function automatic void push_load(int r, int c, int s, logic [31:0] value);
        in_item_t it;
        it = noise_item();
        it.kind = KIND_LOAD;
        it.grid_row = 4'(r);
        it.grid_col = 4'(c);
        it.grid_step = 8'(s);
        it.sample_value = value;
        word_loaded[grid_addr(r, c, s)] = 1'b1;
        pending_items.push_back(it);
        loads_sent++;
        items_sent++;
    endfunction

    // query, preceded by loads of any neighbor not yet written
    function automatic void push_query(in_item_t it);
        cell_t c;
        it.kind = KIND_QUERY;
        c = locate(it);
        if (!c.off_grid) begin
            for (int k = 0; k < 8; k++) begin
                if (!word_loaded[grid_addr(c.zi + k[0], c.yi + k[1], c.ti + k[2])])
                    push_load(int'(c.zi + k[0]), int'(c.yi + k[1]), int'(c.ti + k[2]),
                              $urandom);
            end
        end
        pending_items.push_back(it);
        items_sent++;
    endfunction

    function automatic longint pick_offset(longint span);
        int r;
        r = $urandom_range(0, 19);
        if (span <= 0) return 0;
        if (r == 0) return 0;
        if (r == 1) return span - 1;
        if (r == 2) return span;
        if (r == 3) return -1;
        return longint'($urandom_range(0, 32'(span - 1)));
    endfunction

    // query aimed inside the grid with random content
    function automatic in_item_t aimed_query();
        in_item_t it;
        longint   half, td, px;
        it = noise_item();
        half = longint'(regs.field_size) >> 1;
        it.pos_z = 32'(pick_offset(regs.field_size) - half);
        it.pos_y = 32'(pick_offset(regs.field_size) - half);
        px = half + longint'($urandom_range(0, 1 << 20)) - (1 << 19);
        it.pos_x = 32'(px);
        td = pick_offset(regs.sim_duration);
        it.query_time = 32'(td - (((half - longint'(it.pos_x))
                                   * longint'(regs.inv_hub_speed)) >>> 16));
        return it;
    endfunction

    task automatic set_phase(int p);
        longint span, dur, hub;
        span = $urandom_range(10, 200);
        dur  = $urandom_range(10, 600);
        hub  = $urandom_range(3, 25);
        if (p == 3) hub = -hub;
        if (p == 7) span = $urandom_range(1, 4);
        case (p)
            2: begin
                write_reg(REG_FIELD_SIZE, 32'h7FFF_FFFF);
                write_reg(REG_SIM_DURATION, 32'h7FFF_FFFF);
                write_reg(REG_HUB_SPEED, 32'h7FFF_FFFF);
                write_reg(REG_INV_HUB_SPEED, 32'h8000_0000);
                write_reg(REG_INV_SPATIAL_STEP, 32'h7FFF_FFFF);
                write_reg(REG_INV_TEMPORAL_STEP, 32'h7FFF_FFFF);
            end
            6: begin
                write_reg(REG_FIELD_SIZE, '0);
                write_reg(REG_SIM_DURATION, '0);
                write_reg(REG_HUB_SPEED, 32'h8000_0000);
                write_reg(REG_INV_HUB_SPEED, '0);
                write_reg(REG_INV_SPATIAL_STEP, '0);
                write_reg(REG_INV_TEMPORAL_STEP, '0);
            end
            default: begin
                write_reg(REG_FIELD_SIZE, 32'(span << 16));
                write_reg(REG_SIM_DURATION, 32'(dur << 16));
                write_reg(REG_HUB_SPEED, 32'(hub << 16));
                write_reg(REG_INV_HUB_SPEED, 32'((longint'(1) << 32) / (hub << 16)));
                // one spacing too fine pushes indices onto the last grid point
                write_reg(REG_INV_SPATIAL_STEP,
                          32'(((p == 4 ? GRID_POINTS : GRID_POINTS - 1) << 16) / span));
                write_reg(REG_INV_TEMPORAL_STEP, 32'(((TIME_STEPS - 1) << 16) / dur));
            end
        endcase
    endtask

    initial begin
        in_item_t it;
        int       base;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: grid corners, value extremes, queries at field extremes
        push_load(0, 0, 0, 32'h8000_0000);
        push_load(GRID_POINTS - 1, GRID_POINTS - 1, TIME_STEPS - 1, 32'h7FFF_FFFF);
        push_load(GRID_POINTS - 1, 0, TIME_STEPS - 1, 32'hFFFF_FFFF);
        push_load(0, GRID_POINTS - 1, 0, '0);
        for (int k = 0; k < 8; k++) begin
            it = '0;
            it.pos_x = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            it.pos_y = k[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
            it.pos_z = k[2] ? 32'h7FFF_FFFF : 32'h8000_0000;
            it.query_time = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            push_query(it);
        end
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase(p);
            no_idle = (p == 5);
            base = items_sent;
            // a query on the height edge of the field and one shifted earlier in time first
            it = aimed_query();
            it.pos_z = 32'(longint'(regs.field_size) - (longint'(regs.field_size) >> 1) - 1);
            push_query(it);
            it = aimed_query();
            it.query_time = it.query_time - 32'(1 << 20);
            push_query(it);
            while (items_sent - base < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0:       push_query(noise_item());
                    1:       push_load($urandom_range(0, 15), $urandom_range(0, 15),
                                       $urandom_range(0, 255), $urandom);
                    default: push_query(aimed_query());
                endcase
                if (pending_items.size() > 64)
                    while (pending_items.size() > 16) @(posedge aclk);
            end
            wait_idle();
        end

        $display("covered %0d grid loads and %0d queries, %0d of them outside the grid,",
                 loads_sent, queries_seen, outside_seen);
        $display("over %0d register settings including all-zero and full-scale", NUM_PHASES);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/wgtl_pkg.sv
rtl/wgtl_ram.sv
rtl/wgtl_front.sv
rtl/wgtl_queue.sv
rtl/wgtl_back.sv
rtl/wind_grid_trilinear_lookup.sv
sim/tb_top.sv
